[rtl/rpt_pkg.sv]
package rpt_pkg;

  // fixed field widths
  localparam int OFF_W       = 16;
  localparam int CNT_W       = 16;
  localparam int COUNT_LIMIT = 65535;
  localparam int MAX_RESULTS = 6;

  // bound accumulation stops once accum + digit reaches this
  localparam logic [CNT_W:0]   NUM_LIMIT = (CNT_W+1)'(COUNT_LIMIT / 10);
  localparam logic [CNT_W-1:0] REP_INF   = CNT_W'(COUNT_LIMIT);

  typedef enum logic [4:0] {
    KIND_INVALID       = 5'd0,
    KIND_ASSERT_END    = 5'd1,
    KIND_ASSERT_START  = 5'd2,
    KIND_ANY           = 5'd3,
    KIND_CAPTURE       = 5'd4,
    KIND_SET           = 5'd5,
    KIND_SET_NOT       = 5'd6,
    KIND_CLOSE         = 5'd7,
    KIND_END           = 5'd8,
    KIND_GREEDY        = 5'd9,
    KIND_GROUP         = 5'd10,
    KIND_LAZY          = 5'd11,
    KIND_LITERAL       = 5'd12,
    KIND_LOOKAHEAD     = 5'd13,
    KIND_LOOKAHEAD_NOT = 5'd14,
    KIND_OR            = 5'd15,
    KIND_REPORT        = 5'd16
  } rpt_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_RBRACKET   = 3'd1,
    ERR_NUMBER     = 3'd2,
    ERR_REPEAT     = 3'd3,
    ERR_RBRACE     = 3'd4,
    ERR_GROUPING   = 3'd5,
    ERR_CHAR       = 3'd6
  } rpt_err_t;

  typedef struct packed {
    rpt_kind_t        token_kind;
    logic [OFF_W-1:0] start_offset;
    logic [OFF_W-1:0] end_offset;
    logic [CNT_W-1:0] repeat_min;
    logic [CNT_W-1:0] repeat_max;
    rpt_err_t         fault_code;
    logic             last_of_run;
  } rpt_result_t;

  typedef struct packed {
    rpt_result_t [MAX_RESULTS-1:0] item;
    logic [2:0]                    count;
  } rpt_batch_t;

  localparam logic [15:0] CH_BANG   = 16'h0021;
  localparam logic [15:0] CH_DOLLAR = 16'h0024;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_RPAREN = 16'h0029;
  localparam logic [15:0] CH_STAR   = 16'h002A;
  localparam logic [15:0] CH_PLUS   = 16'h002B;
  localparam logic [15:0] CH_COMMA  = 16'h002C;
  localparam logic [15:0] CH_DOT    = 16'h002E;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_ZERO   = 16'h0030;
  localparam logic [15:0] CH_NINE   = 16'h0039;
  localparam logic [15:0] CH_COLON  = 16'h003A;
  localparam logic [15:0] CH_EQ     = 16'h003D;
  localparam logic [15:0] CH_QUES   = 16'h003F;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam logic [15:0] CH_RBRACK = 16'h005D;
  localparam logic [15:0] CH_CARET  = 16'h005E;
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_BAR    = 16'h007C;
  localparam logic [15:0] CH_RBRACE = 16'h007D;

endpackage

[rtl/rpt_lexer.sv]
module rpt_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [15:0]         code_unit,
  input  logic                is_last,
  output rpt_pkg::rpt_batch_t batch
);
  import rpt_pkg::*;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_STAR,
    MODE_PLUS,
    MODE_QUES,
    MODE_PAREN,
    MODE_PAREN_Q,
    MODE_ESC,
    MODE_SET_START,
    MODE_SET_BODY,
    MODE_SET_ESC,
    MODE_REP_MIN,
    MODE_REP_MAX,
    MODE_REP_CLOSED
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [OFF_W-1:0] token_start;
    logic [OFF_W-1:0] position;
    logic [CNT_W-1:0] number_accum;
    logic [CNT_W-1:0] held_min;
    logic             digit_seen;
    logic             set_negated;
    logic             at_pattern_start;
  } state_t;

  localparam state_t ST_IDLE = '{
    mode:             MODE_IDLE,
    token_start:      '0,
    position:         '0,
    number_accum:     '0,
    held_min:         '0,
    digit_seen:       1'b0,
    set_negated:      1'b0,
    at_pattern_start: 1'b1
  };

  function automatic rpt_result_t mk(rpt_kind_t k, logic [OFF_W-1:0] s, logic [OFF_W-1:0] e,
                                     logic [CNT_W-1:0] mn, logic [CNT_W-1:0] mx,
                                     rpt_err_t er);
    rpt_result_t r;
    r.token_kind   = k;
    r.start_offset = s;
    r.end_offset   = e;
    r.repeat_min   = mn;
    r.repeat_max   = mx;
    r.fault_code   = er;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] qmin(mode_t m);
    return (m == MODE_PLUS) ? CNT_W'(1) : '0;
  endfunction

  function automatic logic [CNT_W-1:0] qmax(mode_t m);
    return (m == MODE_QUES) ? CNT_W'(1) : REP_INF;
  endfunction

  state_t           state_r;
  state_t           state_nxt;
  logic [OFF_W-1:0] pos;
  logic [OFF_W-1:0] ts;
  logic [OFF_W-1:0] pos_p1;
  logic             is_digit;
  logic [CNT_W:0]   acc_sum;
  logic             overflow;
  logic [CNT_W-1:0] acc_step;
  rpt_result_t      slot [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] slot_v;
  logic             fall;
  logic             restart;
  logic [2:0]       cnt;

  assign pos      = state_r.position;
  assign ts       = state_r.token_start;
  assign pos_p1   = pos + 1'b1;
  assign is_digit = (code_unit >= CH_ZERO) && (code_unit <= CH_NINE);
  assign acc_sum  = {1'b0, state_r.number_accum} + (CNT_W+1)'(code_unit[3:0]);
  assign overflow = acc_sum >= NUM_LIMIT;
  // accum stays below the limit, so times ten still fits
  assign acc_step = (state_r.number_accum << 3) + (state_r.number_accum << 1)
                    + CNT_W'(code_unit[3:0]);

  always_comb begin
    state_nxt          = state_r;
    state_nxt.position = pos_p1;
    fall               = 1'b0;
    restart            = 1'b0;
    slot_v             = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot[i] = '0;
    end

    // pending construct from the previous word
    unique case (state_r.mode)
      MODE_STAR, MODE_PLUS, MODE_QUES: begin
        slot_v[0]      = 1'b1;
        state_nxt.mode = MODE_IDLE;
        if (code_unit == CH_QUES) begin
          slot[0] = mk(KIND_LAZY, ts, pos_p1, qmin(state_r.mode), qmax(state_r.mode), ERR_NONE);
        end else begin
          slot[0] = mk(KIND_GREEDY, ts, pos, qmin(state_r.mode), qmax(state_r.mode), ERR_NONE);
          fall    = 1'b1;
        end
      end
      MODE_PAREN: begin
        if (code_unit == CH_QUES) begin
          state_nxt.mode = MODE_PAREN_Q;
        end else begin
          slot[0]   = mk(KIND_CAPTURE, ts, pos, '0, '0, ERR_NONE);
          slot_v[0] = 1'b1;
          fall      = 1'b1;
        end
      end
      MODE_PAREN_Q: begin
        state_nxt.mode = MODE_IDLE;
        slot_v[0]      = 1'b1;
        if (code_unit == CH_COLON) begin
          slot[0] = mk(KIND_GROUP, ts, pos_p1, '0, '0, ERR_NONE);
        end else if (code_unit == CH_EQ) begin
          slot[0] = mk(KIND_LOOKAHEAD, ts, pos_p1, '0, '0, ERR_NONE);
        end else if (code_unit == CH_BANG) begin
          slot[0] = mk(KIND_LOOKAHEAD_NOT, ts, pos_p1, '0, '0, ERR_NONE);
        end else begin
          slot[0]   = mk(KIND_REPORT, ts, pos, '0, '0, ERR_GROUPING);
          slot[1]   = mk(KIND_GROUP, ts, pos, '0, '0, ERR_NONE);
          slot_v[1] = 1'b1;
          fall      = 1'b1;
        end
      end
      MODE_ESC: begin
        slot[0]        = mk(KIND_LITERAL, ts, pos_p1, '0, '0, ERR_NONE);
        slot_v[0]      = 1'b1;
        state_nxt.mode = MODE_IDLE;
      end
      MODE_SET_START, MODE_SET_BODY: begin
        if (state_r.mode == MODE_SET_START && code_unit == CH_CARET) begin
          state_nxt.set_negated = 1'b1;
          state_nxt.mode        = MODE_SET_BODY;
        end else if (code_unit == CH_RBRACK) begin
          slot[0]        = mk(state_r.set_negated ? KIND_SET_NOT : KIND_SET, ts, pos_p1,
                              '0, '0, ERR_NONE);
          slot_v[0]      = 1'b1;
          state_nxt.mode = MODE_IDLE;
        end else if (code_unit == CH_BSLASH) begin
          state_nxt.mode = MODE_SET_ESC;
        end else begin
          state_nxt.mode = MODE_SET_BODY;
        end
      end
      MODE_SET_ESC: begin
        state_nxt.mode = MODE_SET_BODY;
      end
      MODE_REP_MIN, MODE_REP_MAX: begin
        if (is_digit) begin
          state_nxt.digit_seen = 1'b1;
          if (overflow) begin
            slot[0]   = mk(KIND_REPORT, ts, pos_p1, '0, '0, ERR_NUMBER);
            slot_v[0] = 1'b1;
          end else begin
            state_nxt.number_accum = acc_step;
          end
        end else begin
          if (!state_r.digit_seen) begin
            slot[0]   = mk(KIND_REPORT, ts, pos, '0, '0, ERR_NUMBER);
            slot_v[0] = 1'b1;
          end
          if (code_unit == CH_RBRACE) begin
            if (state_r.mode == MODE_REP_MIN) begin
              state_nxt.held_min = state_r.number_accum;
            end
            state_nxt.mode = MODE_REP_CLOSED;
          end else if (state_r.mode == MODE_REP_MIN && code_unit == CH_COMMA) begin
            state_nxt.held_min     = state_r.number_accum;
            state_nxt.number_accum = '0;
            state_nxt.digit_seen   = 1'b0;
            state_nxt.mode         = MODE_REP_MAX;
          end else begin
            slot[1]        = mk(KIND_INVALID, ts, pos, '0, '0,
                                (state_r.mode == MODE_REP_MIN) ? ERR_REPEAT : ERR_RBRACE);
            slot_v[1]      = 1'b1;
            state_nxt.mode = MODE_IDLE;
            fall           = 1'b1;
          end
        end
      end
      MODE_REP_CLOSED: begin
        state_nxt.mode = MODE_IDLE;
        slot_v[0]      = 1'b1;
        if (code_unit == CH_QUES) begin
          slot[0] = mk(KIND_LAZY, ts, pos_p1, state_r.held_min, state_r.number_accum, ERR_NONE);
        end else begin
          slot[0] = mk(KIND_GREEDY, ts, pos, state_r.held_min, state_r.number_accum, ERR_NONE);
          fall    = 1'b1;
        end
      end
      default: begin
        fall = 1'b1;
      end
    endcase

    // word opens a new token
    if (fall) begin
      state_nxt.mode             = MODE_IDLE;
      state_nxt.token_start      = pos;
      state_nxt.at_pattern_start = 1'b0;
      unique case (code_unit)
        CH_DOLLAR: begin
          slot[2]   = mk(is_last ? KIND_ASSERT_END : KIND_LITERAL, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
        CH_STAR:  state_nxt.mode = MODE_STAR;
        CH_PLUS:  state_nxt.mode = MODE_PLUS;
        CH_QUES:  state_nxt.mode = MODE_QUES;
        CH_DOT: begin
          slot[2]   = mk(KIND_ANY, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
        CH_SLASH: begin
          slot[2]   = mk(KIND_END, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
          restart   = 1'b1;
        end
        CH_LPAREN: state_nxt.mode = MODE_PAREN;
        CH_RPAREN: begin
          slot[2]   = mk(KIND_CLOSE, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
        CH_LBRACK: begin
          state_nxt.mode        = MODE_SET_START;
          state_nxt.set_negated = 1'b0;
        end
        CH_LBRACE: begin
          state_nxt.mode         = MODE_REP_MIN;
          state_nxt.number_accum = '0;
          state_nxt.held_min     = '0;
          state_nxt.digit_seen   = 1'b0;
        end
        CH_CARET: begin
          slot[2]   = mk(state_r.at_pattern_start ? KIND_ASSERT_START : KIND_LITERAL,
                         pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
        CH_BAR: begin
          slot[2]   = mk(KIND_OR, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
        CH_BSLASH: state_nxt.mode = MODE_ESC;
        default: begin
          slot[2]   = mk(KIND_LITERAL, pos, pos_p1, '0, '0, ERR_NONE);
          slot_v[2] = 1'b1;
        end
      endcase
    end

    // end of pattern: close whatever is open, then end token
    if (is_last && !restart) begin
      unique case (state_nxt.mode)
        MODE_STAR, MODE_PLUS, MODE_QUES: begin
          slot[3]   = mk(KIND_GREEDY, state_nxt.token_start, pos_p1, qmin(state_nxt.mode),
                         qmax(state_nxt.mode), ERR_NONE);
          slot_v[3] = 1'b1;
        end
        MODE_PAREN: begin
          slot[3]   = mk(KIND_CAPTURE, state_nxt.token_start, pos_p1, '0, '0, ERR_NONE);
          slot_v[3] = 1'b1;
        end
        MODE_PAREN_Q: begin
          slot[3]   = mk(KIND_REPORT, state_nxt.token_start, pos_p1, '0, '0, ERR_GROUPING);
          slot[4]   = mk(KIND_GROUP, state_nxt.token_start, pos_p1, '0, '0, ERR_NONE);
          slot_v[4:3] = 2'b11;
        end
        MODE_ESC: begin
          slot[3]   = mk(KIND_REPORT, state_nxt.token_start, pos_p1, '0, '0, ERR_CHAR);
          slot[4]   = mk(KIND_LITERAL, state_nxt.token_start, pos_p1, '0, '0, ERR_NONE);
          slot_v[4:3] = 2'b11;
        end
        MODE_SET_START, MODE_SET_BODY, MODE_SET_ESC: begin
          slot[3]   = mk(KIND_REPORT, state_nxt.token_start, pos_p1, '0, '0, ERR_RBRACKET);
          slot[4]   = mk(state_nxt.set_negated ? KIND_SET_NOT : KIND_SET,
                         state_nxt.token_start, pos_p1, '0, '0, ERR_NONE);
          slot_v[4:3] = 2'b11;
        end
        MODE_REP_MIN, MODE_REP_MAX: begin
          slot[3]   = mk(KIND_REPORT, state_nxt.token_start, pos_p1, '0, '0, ERR_NUMBER);
          slot_v[3] = !state_nxt.digit_seen;
          slot[4]   = mk(KIND_INVALID, state_nxt.token_start, pos_p1, '0, '0,
                         (state_nxt.mode == MODE_REP_MIN) ? ERR_REPEAT : ERR_RBRACE);
          slot_v[4] = 1'b1;
        end
        MODE_REP_CLOSED: begin
          slot[3]   = mk(KIND_GREEDY, state_nxt.token_start, pos_p1, state_nxt.held_min,
                         state_nxt.number_accum, ERR_NONE);
          slot_v[3] = 1'b1;
        end
        default: begin
          slot_v[3] = 1'b0;
        end
      endcase
      slot[5]   = mk(KIND_END, pos_p1, pos_p1, '0, '0, ERR_NONE);
      slot_v[5] = 1'b1;
      restart   = 1'b1;
    end

    if (restart) begin
      state_nxt = ST_IDLE;
    end

    // pack the used slots in order
    batch = '0;
    cnt   = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (slot_v[i]) begin
        batch.item[cnt] = slot[i];
        cnt             = cnt + 3'd1;
      end
    end
    if (cnt != 3'd0) begin
      batch.item[cnt - 3'd1].last_of_run = 1'b1;
    end
    batch.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/rpt_result_buf.sv]
module rpt_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rpt_pkg::rpt_batch_t  batch,
  input  logic                 out_ready,
  output logic                 free,
  output logic                 out_valid,
  output rpt_pkg::rpt_result_t out_item
);
  import rpt_pkg::*;

  rpt_result_t item_r [MAX_RESULTS];
  logic [2:0]  cnt_r;
  logic        pop;

  assign out_valid = cnt_r != 3'd0;
  assign out_item  = item_r[0];
  assign pop       = out_valid && out_ready;
  // room for a new batch once the last waiting word leaves
  assign free      = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        item_r[i] <= batch.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        item_r[i] <= item_r[i+1];
      end
    end
  end

endmodule

[rtl/regex_pattern_tokenizer_top.sv]
// path: input register, then lexer into the result buffer register that drives out_*
// throughput: one input word per cycle while each word yields at most one result and
//   out_tready is high; a word that yields more results holds the input while the
//   result buffer drains one word per cycle that out_tready is high
// reset: synchronous active-low rst_n clears the input stage, the result buffer
//   and the scan state to idle at pattern start

module regex_pattern_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // start_offset, end_offset, repeat_min, repeat_max,
                                  // fault_code, zero fill
  output logic [4:0]  out_tuser,  // token_kind
  output logic        out_tlast   // last_of_run
);
  import rpt_pkg::*;

  logic        in_vld_r;
  logic [15:0] in_char_r;
  logic        in_last_r;
  logic        load;
  logic        buf_free;
  rpt_batch_t  batch;
  rpt_result_t out_item;

  assign load      = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  rpt_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .code_unit (in_char_r),
    .is_last   (in_last_r),
    .batch     (batch)
  );

  rpt_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .batch     (batch),
    .out_ready (out_tready),
    .free      (buf_free),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  assign out_tdata = {5'b0, out_item.fault_code, out_item.repeat_max, out_item.repeat_min,
                      out_item.end_offset, out_item.start_offset};
  assign out_tuser = out_item.token_kind;
  assign out_tlast = out_item.last_of_run;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rpt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [3:0] {
    LX_IDLE, LX_STAR, LX_PLUS, LX_QUES, LX_PAREN, LX_PAREN_Q, LX_ESC,
    LX_SET_START, LX_SET_BODY, LX_SET_ESC, LX_REP_MIN, LX_REP_MAX, LX_REP_CLOSED
  } lex_mode_t;

  localparam logic [15:0] SPECIALS [21] = '{
    CH_BANG, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS, CH_COMMA,
    CH_DOT, CH_SLASH, CH_ZERO, CH_NINE, CH_COLON, CH_EQ, CH_QUES, CH_LBRACK,
    CH_BSLASH, CH_RBRACK, CH_CARET, CH_LBRACE, CH_BAR, CH_RBRACE
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  regex_pattern_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lexer state mirrored by the predictor
  lex_mode_t   lex_mode = LX_IDLE;
  logic [15:0] tok_start = '0;
  logic [15:0] char_pos = '0;
  logic [15:0] bound_accum = '0;
  logic [15:0] lo_bound = '0;
  bit          seen_digit = 1'b0;
  bit          set_neg = 1'b0;
  bit          pat_first = 1'b1;

  rpt_result_t char_tokens[$];
  rpt_result_t pending_tokens[$];
  logic [15:0] pat_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int n_errors = 0;
  int n_chars = 0;
  int n_patterns = 0;
  int n_tokens = 0;
  int n_reports = 0;
  int cycle_count = 0;

  function void clear_lexer();
    lex_mode = LX_IDLE;
    tok_start = '0;
    char_pos = '0;
    bound_accum = '0;
    lo_bound = '0;
    seen_digit = 1'b0;
    set_neg = 1'b0;
    pat_first = 1'b1;
  endfunction

  function void note_token(rpt_kind_t k, logic [15:0] s, logic [15:0] e,
                           logic [15:0] mn, logic [15:0] mx, rpt_err_t err);
    rpt_result_t r;
    r.token_kind = k;
    r.start_offset = s;
    r.end_offset = e;
    r.repeat_min = mn;
    r.repeat_max = mx;
    r.fault_code = err;
    r.last_of_run = 1'b0;
    if (char_tokens.size() < MAX_RESULTS) char_tokens = {char_tokens, r};
  endfunction

  // returns 1 when the character restarted the lexer
  function bit lex_char(logic [15:0] c, bit last);
    logic [15:0] p1;
    logic [15:0] digit;
    logic [15:0] qmin;
    logic [15:0] qmax;
    bit          first;
    bit          done;
    bit          restarted;
    rpt_kind_t   k;
    p1 = char_pos + 16'd1;
    done = 1'b0;
    restarted = 1'b0;
    while (!done) begin
      case (lex_mode)
        LX_STAR, LX_PLUS, LX_QUES: begin
          qmin = (lex_mode == LX_PLUS) ? 16'd1 : 16'd0;
          qmax = (lex_mode == LX_QUES) ? 16'd1 : REP_INF;
          lex_mode = LX_IDLE;
          if (c == CH_QUES) begin
            note_token(KIND_LAZY, tok_start, p1, qmin, qmax, ERR_NONE);
            char_pos = p1;
            done = 1'b1;
          end else begin
            note_token(KIND_GREEDY, tok_start, char_pos, qmin, qmax, ERR_NONE);
          end
        end
        LX_PAREN: begin
          if (c == CH_QUES) begin
            lex_mode = LX_PAREN_Q;
            char_pos = p1;
            done = 1'b1;
          end else begin
            note_token(KIND_CAPTURE, tok_start, char_pos, '0, '0, ERR_NONE);
            lex_mode = LX_IDLE;
          end
        end
        LX_PAREN_Q: begin
          lex_mode = LX_IDLE;
          if (c == CH_COLON || c == CH_EQ || c == CH_BANG) begin
            k = (c == CH_COLON) ? KIND_GROUP :
                (c == CH_EQ) ? KIND_LOOKAHEAD : KIND_LOOKAHEAD_NOT;
            note_token(k, tok_start, p1, '0, '0, ERR_NONE);
            char_pos = p1;
            done = 1'b1;
          end else begin
            note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_GROUPING);
            note_token(KIND_GROUP, tok_start, char_pos, '0, '0, ERR_NONE);
          end
        end
        LX_ESC: begin
          note_token(KIND_LITERAL, tok_start, p1, '0, '0, ERR_NONE);
          lex_mode = LX_IDLE;
          char_pos = p1;
          done = 1'b1;
        end
        LX_SET_START: begin
          lex_mode = LX_SET_BODY;
          if (c == CH_CARET) begin
            set_neg = 1'b1;
            char_pos = p1;
            done = 1'b1;
          end
        end
        LX_SET_BODY: begin
          if (c == CH_RBRACK) begin
            note_token(set_neg ? KIND_SET_NOT : KIND_SET, tok_start, p1, '0, '0, ERR_NONE);
            lex_mode = LX_IDLE;
          end else if (c == CH_BSLASH) begin
            lex_mode = LX_SET_ESC;
          end
          char_pos = p1;
          done = 1'b1;
        end
        LX_SET_ESC: begin
          lex_mode = LX_SET_BODY;
          char_pos = p1;
          done = 1'b1;
        end
        LX_REP_MIN, LX_REP_MAX: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            digit = c - CH_ZERO;
            seen_digit = 1'b1;
            // digits that would push the bound too far are dropped
            if (int'(bound_accum) + int'(digit) >= COUNT_LIMIT / 10)
              note_token(KIND_REPORT, tok_start, p1, '0, '0, ERR_NUMBER);
            else
              bound_accum = bound_accum * 16'd10 + digit;
            char_pos = p1;
            done = 1'b1;
          end else begin
            if (!seen_digit)
              note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_NUMBER);
            if (c == CH_RBRACE) begin
              if (lex_mode == LX_REP_MIN) lo_bound = bound_accum;
              lex_mode = LX_REP_CLOSED;
              char_pos = p1;
              done = 1'b1;
            end else if (lex_mode == LX_REP_MIN && c == CH_COMMA) begin
              lo_bound = bound_accum;
              bound_accum = '0;
              seen_digit = 1'b0;
              lex_mode = LX_REP_MAX;
              char_pos = p1;
              done = 1'b1;
            end else begin
              note_token(KIND_INVALID, tok_start, char_pos, '0, '0,
                         (lex_mode == LX_REP_MIN) ? ERR_REPEAT : ERR_RBRACE);
              lex_mode = LX_IDLE;
            end
          end
        end
        LX_REP_CLOSED: begin
          lex_mode = LX_IDLE;
          if (c == CH_QUES) begin
            note_token(KIND_LAZY, tok_start, p1, lo_bound, bound_accum, ERR_NONE);
            char_pos = p1;
            done = 1'b1;
          end else begin
            note_token(KIND_GREEDY, tok_start, char_pos, lo_bound, bound_accum, ERR_NONE);
          end
        end
        default: begin
          first = pat_first;
          lex_mode = LX_IDLE;
          tok_start = char_pos;
          pat_first = 1'b0;
          done = 1'b1;
          if (c == CH_SLASH) begin
            note_token(KIND_END, tok_start, p1, '0, '0, ERR_NONE);
            clear_lexer();
            restarted = 1'b1;
          end else begin
            case (c)
              CH_DOLLAR:
                note_token(last ? KIND_ASSERT_END : KIND_LITERAL, tok_start, p1, '0, '0,
                           ERR_NONE);
              CH_STAR:   lex_mode = LX_STAR;
              CH_PLUS:   lex_mode = LX_PLUS;
              CH_QUES:   lex_mode = LX_QUES;
              CH_DOT:    note_token(KIND_ANY, tok_start, p1, '0, '0, ERR_NONE);
              CH_LPAREN: lex_mode = LX_PAREN;
              CH_RPAREN: note_token(KIND_CLOSE, tok_start, p1, '0, '0, ERR_NONE);
              CH_LBRACK: begin
                lex_mode = LX_SET_START;
                set_neg = 1'b0;
              end
              CH_LBRACE: begin
                lex_mode = LX_REP_MIN;
                bound_accum = '0;
                lo_bound = '0;
                seen_digit = 1'b0;
              end
              CH_CARET:
                note_token(first ? KIND_ASSERT_START : KIND_LITERAL, tok_start, p1, '0, '0,
                           ERR_NONE);
              CH_BAR:    note_token(KIND_OR, tok_start, p1, '0, '0, ERR_NONE);
              CH_BSLASH: lex_mode = LX_ESC;
              default:   note_token(KIND_LITERAL, tok_start, p1, '0, '0, ERR_NONE);
            endcase
            char_pos = p1;
          end
        end
      endcase
    end
    return restarted;
  endfunction

  // close whatever is still open when the pattern ends
  function void close_pattern();
    case (lex_mode)
      LX_STAR, LX_PLUS, LX_QUES:
        note_token(KIND_GREEDY, tok_start, char_pos,
                   (lex_mode == LX_PLUS) ? 16'd1 : 16'd0,
                   (lex_mode == LX_QUES) ? 16'd1 : REP_INF, ERR_NONE);
      LX_PAREN: note_token(KIND_CAPTURE, tok_start, char_pos, '0, '0, ERR_NONE);
      LX_PAREN_Q: begin
        note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_GROUPING);
        note_token(KIND_GROUP, tok_start, char_pos, '0, '0, ERR_NONE);
      end
      LX_ESC: begin
        note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_CHAR);
        note_token(KIND_LITERAL, tok_start, char_pos, '0, '0, ERR_NONE);
      end
      LX_SET_START, LX_SET_BODY, LX_SET_ESC: begin
        note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_RBRACKET);
        note_token(set_neg ? KIND_SET_NOT : KIND_SET, tok_start, char_pos, '0, '0, ERR_NONE);
      end
      LX_REP_MIN, LX_REP_MAX: begin
        if (!seen_digit)
          note_token(KIND_REPORT, tok_start, char_pos, '0, '0, ERR_NUMBER);
        note_token(KIND_INVALID, tok_start, char_pos, '0, '0,
                   (lex_mode == LX_REP_MIN) ? ERR_REPEAT : ERR_RBRACE);
      end
      LX_REP_CLOSED:
        note_token(KIND_GREEDY, tok_start, char_pos, lo_bound, bound_accum, ERR_NONE);
      default: ;
    endcase
    note_token(KIND_END, char_pos, char_pos, '0, '0, ERR_NONE);
    clear_lexer();
  endfunction

  function void predict_word(logic [15:0] c, bit last);
    char_tokens.delete();
    if (!lex_char(c, last) && last) close_pattern();
    if (char_tokens.size() > 0) char_tokens[char_tokens.size()-1].last_of_run = 1'b1;
    pending_tokens = {pending_tokens, char_tokens};
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // predict before checking so a word and its results never race
  always @(posedge clk) begin
    rpt_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_word(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pending_tokens.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result word, expected none, actual kind %0d start %0d",
                   $time, out_tuser, out_tdata[15:0]);
        end else begin
          want = pending_tokens.pop_front();
          n_tokens++;
          if (want.token_kind == KIND_REPORT || want.token_kind == KIND_INVALID) n_reports++;
          check_field("token_kind", 32'(want.token_kind), 32'(out_tuser));
          check_field("start_offset", 32'(want.start_offset), 32'(out_tdata[15:0]));
          check_field("end_offset", 32'(want.end_offset), 32'(out_tdata[31:16]));
          check_field("repeat_min", 32'(want.repeat_min), 32'(out_tdata[47:32]));
          check_field("repeat_max", 32'(want.repeat_max), 32'(out_tdata[63:48]));
          check_field("fault_code", 32'(want.fault_code), 32'(out_tdata[66:64]));
          check_field("zero_fill", 32'd0, 32'(out_tdata[71:67]));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_tlast));
        end
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_tokens.size());
      $display("regex_pattern_tokenizer_top verification failed");
      $finish;
    end
  end

  task automatic send_char(logic [15:0] c, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_chars++;
    if (last) n_patterns++;
  endtask

  task automatic send_text(string s, bit last);
    for (int i = 0; i < s.len(); i++)
      send_char(16'(s[i]), last && (i == s.len() - 1));
  endtask

  function void put_char(logic [15:0] c);
    pat_q = {pat_q, c};
  endfunction

  function logic [15:0] pick_special();
    return SPECIALS[$urandom_range(20)];
  endfunction

  function logic [15:0] pick_letter();
    return 16'h0061 + 16'($urandom_range(25));
  endfunction

  function void add_digits(int n);
    repeat (n) put_char(CH_ZERO + 16'($urandom_range(9)));
  endfunction

  function int bound_width();
    // mostly short bounds, now and then long enough to overflow
    return ($urandom_range(7) == 0) ? $urandom_range(6, 4) : $urandom_range(2);
  endfunction

  function void add_fragment();
    int sel;
    int n;
    sel = $urandom_range(19);
    case (sel)
      0, 1, 2: put_char(pick_letter());
      3:  put_char(16'($urandom_range(16'hFFFF)));
      4:  put_char(CH_DOT);
      5:  put_char(CH_BAR);
      6:  put_char(CH_LPAREN);
      7:  put_char(CH_RPAREN);
      8: begin
        put_char(CH_LPAREN);
        put_char(CH_QUES);
        case ($urandom_range(3))
          0: put_char(CH_COLON);
          1: put_char(CH_EQ);
          2: put_char(CH_BANG);
          default: put_char(($urandom_range(1) == 0) ? pick_letter() : pick_special());
        endcase
      end
      9: begin
        put_char(CH_BSLASH);
        put_char(($urandom_range(1) == 0) ? pick_special() : pick_letter());
      end
      10, 11: begin
        put_char(CH_LBRACK);
        if ($urandom_range(2) == 0) put_char(CH_CARET);
        n = $urandom_range(4);
        repeat (n) begin
          if ($urandom_range(3) == 0) begin
            put_char(CH_BSLASH);
            put_char(pick_special());
          end else begin
            put_char(($urandom_range(2) == 0) ? pick_special() : pick_letter());
          end
        end
        if ($urandom_range(5) != 0) put_char(CH_RBRACK);
      end
      12, 13: begin
        case ($urandom_range(2))
          0: put_char(CH_STAR);
          1: put_char(CH_PLUS);
          default: put_char(CH_QUES);
        endcase
        if ($urandom_range(2) == 0) put_char(CH_QUES);
      end
      14, 15: begin
        put_char(CH_LBRACE);
        add_digits(bound_width());
        if ($urandom_range(2) == 0) begin
          put_char(CH_COMMA);
          add_digits(bound_width());
        end
        if ($urandom_range(5) == 0) begin
          put_char(($urandom_range(1) == 0) ? pick_letter() : pick_special());
        end else begin
          put_char(CH_RBRACE);
          if ($urandom_range(2) == 0) put_char(CH_QUES);
        end
      end
      16: put_char(CH_CARET);
      17: put_char(CH_DOLLAR);
      18: put_char(CH_SLASH);
      default: put_char(pick_special());
    endcase
  endfunction

  task automatic test_anchors_and_extremes();
    send_text("^$", 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_text(".|^$", 1'b1);
  endtask

  task automatic test_groups();
    send_text("(?:(?!)(a(?a(", 1'b1);
  endtask

  task automatic test_quantifiers();
    send_text("*?+{2,5}?{,99999}/", 1'b0);
  endtask

  task automatic test_malformed();
    send_text("{3x{4,}[\\]^]\\", 1'b1);
  endtask

  task automatic test_open_endings();
    send_text("+", 1'b1);
    send_text("[^", 1'b1);
    send_text("{7", 1'b1);
    send_text("/", 1'b1);
  endtask

  task automatic test_random_patterns(int idle, int stall, int n_words);
    int sent;
    int nfrag;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_words) begin
      pat_q.delete();
      nfrag = $urandom_range(1, 10);
      repeat (nfrag) add_fragment();
      foreach (pat_q[i]) send_char(pat_q[i], i == pat_q.size() - 1);
      sent += pat_q.size();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_anchors_and_extremes();
    test_groups();
    test_quantifiers();
    test_malformed();
    test_open_endings();

    test_random_patterns(0, 0, 95);
    test_random_patterns(59, 0, 95);
    test_random_patterns(0, 59, 95);
    test_random_patterns(12, 12, 95);

    in_tvalid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("lexed %0d pattern words in %0d terminated patterns", n_chars, n_patterns);
    $display("checked %0d result words, %0d of them error reports or invalid tokens",
             n_tokens, n_reports);
    if (n_errors == 0 && pending_tokens.size() == 0) begin
      $display("regex_pattern_tokenizer_top verification clean");
    end else begin
      $display("regex_pattern_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
